@@ rtl/msps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_pkg: shared types and codes of the priority send scheduler
// word formats, operation and status codes, register indexes, defaults
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int NUM_RINGS       = 8;
    localparam int NUM_CLASSES     = 10;

    // operation codes
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_TX_RDY  = 2'd1;
    localparam logic [1:0] OP_POST    = 2'd2;

    // status codes
    localparam logic [3:0] ST_SCHEDULED   = 4'd0;
    localparam logic [3:0] ST_FULL        = 4'd1;
    localparam logic [3:0] ST_NODEV       = 4'd2;
    localparam logic [3:0] ST_OVERWRITTEN = 4'd3;
    localparam logic [3:0] ST_SENT        = 4'd4;
    localparam logic [3:0] ST_IDLE        = 4'd5;
    localparam logic [3:0] ST_POSTED      = 4'd6;
    localparam logic [3:0] ST_MISSED      = 4'd7;
    localparam logic [3:0] ST_BADCLASS    = 4'd8;

    // class numbers of the reply slots
    localparam logic [3:0] CLS_REPLY     = 4'd0;
    localparam logic [3:0] CLS_EXT_REPLY = 4'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_BCST_REQ_CAP  = 3'd0;
    localparam logic [2:0] CFG_BCST_CMD_CAP  = 3'd1;
    localparam logic [2:0] CFG_SNGL_REQ_CAP  = 3'd2;
    localparam logic [2:0] CFG_SNGL_CMD_CAP  = 3'd3;
    localparam logic [2:0] CFG_EXT_QUEUE_CAP = 3'd4;
    localparam logic [2:0] CFG_DEVICE_COUNT  = 3'd5;
    localparam logic [2:0] CFG_SLOT_TIME     = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  queue_class;
        logic [15:0] msg_handle;
        logic        reply_ready;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] sent_handle;
        logic [3:0]  sent_class;
        logic [21:0] send_delay;
        logic [6:0]  free_slots;
    } rsp_t;

    // ring of a queued class, valid only for classes 1-4 and 6-9
    typedef struct packed {
        logic       valid;
        logic [2:0] ring;
    } ring_sel_t;

    function automatic ring_sel_t ring_of(logic [3:0] cls);
        ring_sel_t r;
        r.valid = 1'b0;
        r.ring  = 3'd0;
        if (cls >= 4'd1 && cls <= 4'd4)
        begin
            r.valid = 1'b1;
            r.ring  = 3'(cls - 4'd1);
        end
        else if (cls >= 4'd6 && cls <= 4'd9)
        begin
            r.valid = 1'b1;
            r.ring  = 3'(cls - 4'd2);
        end
        return r;
    endfunction

endpackage

@@ rtl/msps_qmem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_qmem: handle store of all queue rings
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module msps_qmem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/msps_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_pick: strict priority pick
// lowest numbered class that holds a word
// ----------------------------------------------------------------------------
module msps_pick (
    input  logic [msps_pkg::NUM_CLASSES-1:0] busy,
    output logic                             found,
    output logic [3:0]                       cls
);

    always_comb
    begin
        found = 1'b0;
        cls   = 4'd0;
        for (int i = msps_pkg::NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (busy[i])
            begin
                found = 1'b1;
                cls   = 4'(i);
            end
        end
    end

endmodule

@@ rtl/multi_class_priority_send_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_class_priority_send_scheduler: strict priority send scheduler
// ten message classes, eight handle rings and two reply slots, one transmitter
// ----------------------------------------------------------------------------
// Ten classes of message handles share one transmitter. Classes 1-4 are rings
// that reject a word when full, classes 6-9 rings that overwrite their head
// when full, and classes 0 and 5 one-entry reply slots. A transmitter-ready
// word sends from the lowest numbered class that holds a handle and returns
// the wait time that goes with it. Every request word gives exactly one
// response word. The block takes one request word per cycle while the response
// channel is not stalled; a response passes the input register, the state
// update with the ring memory access and the result register in that order, and a
// stalled response holds back new requests only once the pipeline has filled.
// Ring entries are never cleared: a slot is only read after it was written.
// Configuration writes are meant to happen while no word is in flight.
// ----------------------------------------------------------------------------
module multi_class_priority_send_scheduler #(
    parameter int QUEUE_DEPTH = msps_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = msps_pkg::HANDLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    // request channel
    input  logic            req_valid,
    output logic            req_ready,
    input  msps_pkg::req_t  req,
    // response channel
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output msps_pkg::rsp_t  rsp,
    // configuration writes
    input  logic            cfg_we,
    input  logic [2:0]      cfg_idx,
    input  logic [13:0]     cfg_data
);

    localparam int PW   = $clog2(QUEUE_DEPTH);          // ring position
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);      // fill count
    localparam int MD   = msps_pkg::NUM_RINGS * QUEUE_DEPTH;
    localparam int AW   = $clog2(MD);
    localparam int NR   = msps_pkg::NUM_RINGS;

    // configuration registers
    logic [6:0]  bcst_req_cap_reg;
    logic [6:0]  bcst_cmd_cap_reg;
    logic [6:0]  sngl_req_cap_reg;
    logic [6:0]  sngl_cmd_cap_reg;
    logic [6:0]  ext_queue_cap_reg;
    logic [7:0]  device_count_reg;
    logic [13:0] slot_time_reg;

    // ring and reply slot state
    logic [PW-1:0]          head_reg [NR];
    logic [FW-1:0]          fill_reg [NR];
    logic [HANDLE_BITS-1:0] slot_handle_reg [2];
    logic [1:0]             slot_full_reg;

    // pipeline registers
    logic            a_valid_reg;
    msps_pkg::req_t  a_req_reg;
    logic            b_valid_reg;
    msps_pkg::rsp_t  b_rsp_reg;
    logic            b_from_mem_reg;
    logic            rsp_valid_reg;
    msps_pkg::rsp_t  rsp_reg;
    msps_pkg::rsp_t  rsp_next;

    logic a_move;
    logic b_move;

    // effective capacity: zero acts as one, clamp to the ring depth
    function automatic logic [FW-1:0] cap_eff(logic [6:0] raw);
        logic [6:0] c;
        c = (raw == 7'd0) ? 7'd1 : raw;
        if (int'(c) > QUEUE_DEPTH)
        begin
            return FW'(QUEUE_DEPTH);
        end
        return FW'(c);
    endfunction

    function automatic logic [6:0] free_of(logic [FW-1:0] cap, logic [FW-1:0] fill);
        if (fill >= cap)
        begin
            return 7'd0;
        end
        return 7'(cap - fill);
    endfunction

    // handshakes: each stage moves when the one after it has room
    assign b_move    = b_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign a_move    = a_valid_reg && (!b_valid_reg || b_move);
    assign req_ready = !a_valid_reg || a_move;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // priority pick over all classes
    logic [msps_pkg::NUM_CLASSES-1:0] busy;
    logic                             pick_found;
    logic [3:0]                       pick_cls;

    always_comb
    begin
        busy = '0;
        busy[0] = slot_full_reg[0];
        busy[5] = slot_full_reg[1];
        for (int i = 0; i < 4; i++)
        begin
            busy[i + 1] = (fill_reg[i] != '0);
            busy[i + 6] = (fill_reg[i + 4] != '0);
        end
    end

    msps_pick u_pick (
        .busy  (busy),
        .found (pick_found),
        .cls   (pick_cls)
    );

    // ring selection: the addressed class for an enqueue, the picked one for a send
    msps_pkg::ring_sel_t enq_sel;
    msps_pkg::ring_sel_t pick_sel;
    logic [2:0]          ring;
    logic [FW-1:0]       cap;
    logic [PW-1:0]       head;
    logic [FW-1:0]       fill;
    logic [FW:0]         pos_sum;
    logic [PW-1:0]       tail_pos;
    logic [PW-1:0]       head_inc;

    assign enq_sel  = msps_pkg::ring_of(a_req_reg.queue_class);
    assign pick_sel = msps_pkg::ring_of(pick_cls);
    assign ring     = (a_req_reg.operation == msps_pkg::OP_ENQUEUE) ? enq_sel.ring
                                                                    : pick_sel.ring;
    assign head     = head_reg[ring];
    assign fill     = fill_reg[ring];
    assign pos_sum  = (FW + 1)'(head) + (FW + 1)'(fill);
    assign tail_pos = (pos_sum >= (FW + 1)'(QUEUE_DEPTH))
                      ? PW'(pos_sum - (FW + 1)'(QUEUE_DEPTH)) : PW'(pos_sum);
    assign head_inc = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

    always_comb
    begin
        case (ring)
            3'd0:    cap = cap_eff(bcst_cmd_cap_reg);
            3'd1:    cap = cap_eff(sngl_cmd_cap_reg);
            3'd2:    cap = cap_eff(bcst_req_cap_reg);
            3'd3:    cap = cap_eff(sngl_req_cap_reg);
            default: cap = cap_eff(ext_queue_cap_reg);
        endcase
    end

    // stage a decisions
    msps_pkg::rsp_t         res;
    logic                   from_mem;
    logic                   mem_we;
    logic [PW-1:0]          mem_wpos;
    logic                   mem_re;
    logic                   ring_upd;
    logic [PW-1:0]          head_next;
    logic [FW-1:0]          fill_next;
    logic                   slot_upd;
    logic                   slot_k;
    logic                   slot_full_next;
    logic                   slot_wr;
    logic [21:0]            delay_long;

    assign delay_long = 22'(device_count_reg) * 22'(slot_time_reg);

    always_comb
    begin
        res            = '0;
        res.status     = msps_pkg::ST_BADCLASS;
        from_mem       = 1'b0;
        mem_we         = 1'b0;
        mem_wpos       = tail_pos;
        mem_re         = 1'b0;
        ring_upd       = 1'b0;
        head_next      = head;
        fill_next      = fill;
        slot_upd       = 1'b0;
        slot_k         = 1'b0;
        slot_full_next = 1'b0;
        slot_wr        = 1'b0;
        case (a_req_reg.operation)
            msps_pkg::OP_ENQUEUE:
            begin
                if (enq_sel.valid)
                begin
                    res.free_slots = free_of(cap, fill);
                    if (device_count_reg == 8'd0)
                    begin
                        res.status = msps_pkg::ST_NODEV;
                    end
                    else if (fill < cap)
                    begin
                        mem_we         = 1'b1;
                        ring_upd       = 1'b1;
                        fill_next      = fill + 1'b1;
                        res.status     = msps_pkg::ST_SCHEDULED;
                        res.free_slots = free_of(cap, fill + 1'b1);
                    end
                    else if (ring[2])
                    begin
                        // external ring: replace the oldest entry
                        mem_we     = 1'b1;
                        mem_wpos   = head;
                        res.status = msps_pkg::ST_OVERWRITTEN;
                    end
                    else
                    begin
                        res.status = msps_pkg::ST_FULL;
                    end
                end
            end
            msps_pkg::OP_TX_RDY:
            begin
                res.status = msps_pkg::ST_IDLE;
                if (pick_found)
                begin
                    res.status     = msps_pkg::ST_SENT;
                    res.sent_class = pick_cls;
                    if (pick_cls == msps_pkg::CLS_REPLY || pick_cls == msps_pkg::CLS_EXT_REPLY)
                    begin
                        slot_upd        = 1'b1;
                        slot_k          = (pick_cls == msps_pkg::CLS_EXT_REPLY);
                        res.free_slots  = 7'd1;
                        res.sent_handle = 16'(slot_handle_reg[slot_k]);
                    end
                    else
                    begin
                        from_mem       = 1'b1;
                        mem_re         = 1'b1;
                        ring_upd       = 1'b1;
                        head_next      = head_inc;
                        fill_next      = fill - 1'b1;
                        res.free_slots = free_of(cap, fill - 1'b1);
                    end
                    if (pick_cls == 4'd3 || pick_cls == 4'd8)
                    begin
                        res.send_delay = delay_long;
                    end
                    else if (pick_cls == 4'd4 || pick_cls == 4'd9)
                    begin
                        res.send_delay = 22'(slot_time_reg);
                    end
                end
            end
            msps_pkg::OP_POST:
            begin
                if (a_req_reg.queue_class == msps_pkg::CLS_REPLY ||
                    a_req_reg.queue_class == msps_pkg::CLS_EXT_REPLY)
                begin
                    slot_upd = 1'b1;
                    slot_k   = (a_req_reg.queue_class == msps_pkg::CLS_EXT_REPLY);
                    if (a_req_reg.reply_ready)
                    begin
                        slot_full_next = 1'b1;
                        slot_wr        = 1'b1;
                        res.status     = msps_pkg::ST_POSTED;
                    end
                    else
                    begin
                        res.status     = msps_pkg::ST_MISSED;
                        res.free_slots = 7'd1;
                    end
                end
            end
            default:
            begin
                res.status = msps_pkg::ST_BADCLASS;
            end
        endcase
    end

    // ring memory: word address is ring * depth + position
    logic [HANDLE_BITS-1:0] mem_rd_data;

    msps_qmem #(
        .DEPTH (MD),
        .WIDTH (HANDLE_BITS)
    ) u_qmem (
        .clk     (clk),
        .wr_en   (a_move && mem_we),
        .wr_addr (AW'(ring) * AW'(QUEUE_DEPTH) + AW'(mem_wpos)),
        .wr_data (HANDLE_BITS'(a_req_reg.msg_handle)),
        .rd_en   (a_move && mem_re),
        .rd_addr (AW'(ring) * AW'(QUEUE_DEPTH) + AW'(head)),
        .rd_data (mem_rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcst_req_cap_reg  <= 7'd16;
            bcst_cmd_cap_reg  <= 7'd16;
            sngl_req_cap_reg  <= 7'd16;
            sngl_cmd_cap_reg  <= 7'd16;
            ext_queue_cap_reg <= 7'd16;
            device_count_reg  <= 8'd0;
            slot_time_reg     <= 14'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                msps_pkg::CFG_BCST_REQ_CAP:  bcst_req_cap_reg  <= cfg_data[6:0];
                msps_pkg::CFG_BCST_CMD_CAP:  bcst_cmd_cap_reg  <= cfg_data[6:0];
                msps_pkg::CFG_SNGL_REQ_CAP:  sngl_req_cap_reg  <= cfg_data[6:0];
                msps_pkg::CFG_SNGL_CMD_CAP:  sngl_cmd_cap_reg  <= cfg_data[6:0];
                msps_pkg::CFG_EXT_QUEUE_CAP: ext_queue_cap_reg <= cfg_data[6:0];
                msps_pkg::CFG_DEVICE_COUNT:  device_count_reg  <= cfg_data[7:0];
                msps_pkg::CFG_SLOT_TIME:     slot_time_reg     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // ring pointers and reply slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NR; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            slot_full_reg <= '0;
        end
        else if (a_move)
        begin
            if (ring_upd)
            begin
                head_reg[ring] <= head_next;
                fill_reg[ring] <= fill_next;
            end
            if (slot_upd)
            begin
                slot_full_reg[slot_k] <= slot_full_next;
            end
        end
    end

    // reply slot handles, payload only
    always_ff @(posedge clk)
    begin
        if (a_move && slot_wr)
        begin
            slot_handle_reg[slot_k] <= HANDLE_BITS'(a_req_reg.msg_handle);
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                a_valid_reg <= req_valid;
            end
            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_move)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result word: ring handle arrives from the registered memory read
    always_comb
    begin
        rsp_next = b_rsp_reg;
        if (b_from_mem_reg)
        begin
            rsp_next.sent_handle = 16'(mem_rd_data);
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            a_req_reg <= req;
        end
        if (a_move)
        begin
            b_rsp_reg      <= res;
            b_from_mem_reg <= from_mem;
        end
        if (b_move)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
